// ===== rtl/core/ase_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Array search engine package
// Shared constants, operation codes and the command/status bundles that
// join the sequencer to the datapath.
// ----------------------------------------------------------------------------
package ase_pkg;

    localparam int ASE_DEPTH = 256;

    // Register file: one 32-bit register, word-addressed by paddr[2].
    localparam int   ASE_ADDR_W           = 3;
    localparam logic ASE_IDX_ACTIVE_COUNT = 1'b0;

    typedef enum logic [2:0] {
        OP_WRITE   = 3'd0,
        OP_FIRST   = 3'd1,
        OP_COUNT   = 3'd2,
        OP_LAST    = 3'd3,
        OP_REPLACE = 3'd4,
        OP_BINARY  = 3'd5,
        OP_NEAREST = 3'd6
    } ase_op_t;

    typedef struct packed {
        ase_op_t mode;
        logic    load;
        logic    wr_item;
        logic    scan_issue;
        logic    wr_repl;
        logic    bs_issue;
        logic    bs_step;
    } ase_cmd_t;

    typedef struct packed {
        logic scan_more;
        logic range_empty;
        logic cmp_eq;
    } ase_status_t;

endpackage

`default_nettype wire

// ===== rtl/core/array_search_engine_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Array search engine
// Signed 32-bit element store with linear and binary search operations.
// ----------------------------------------------------------------------------
// Usage:
//   A command is taken when start is high and busy is low; op, write_index,
//   search_value and new_value are sampled on that edge. Each command yields
//   one result beat: done is high for exactly one cycle with found, position,
//   tally and nearest_value valid. The receiver cannot stall; the result must
//   be taken in that cycle. A new command is accepted in the cycle after done.
//   Steps from acceptance to done, with n the active element count:
//     write: S_WRITE stores the element; unused op code: straight to S_DONE;
//     first, count, last: n reads in S_SCAN; replace last adds S_REPL;
//     binary and nearest: S_BS_ISSUE then S_BS_CMP per probe, until a probe
//     hits or the window empties.
//   The linear scans read one element per cycle through the single read port
//   of the element memory, whose registered read data feeds the compare.
//   Each binary probe reads in S_BS_ISSUE and compares in S_BS_CMP.
//   The APB port holds active_count at offset 0; write it only while idle.
//   Reset clears active_count and the sequencer; the element store is not
//   cleared, and only elements that have been written may be searched.
// ----------------------------------------------------------------------------
module array_search_engine_unit
    import ase_pkg::*;
#(
    parameter int DEPTH = ASE_DEPTH
) (
    input  wire                     clk,
    input  wire                     rst_n,
    input  wire                     psel,
    input  wire                     penable,
    input  wire                     pwrite,
    input  wire  [ASE_ADDR_W-1:0]   paddr,
    input  wire  [31:0]             pwdata,
    output logic [31:0]             prdata,
    output logic                    pready,
    input  wire                     start,
    output logic                    busy,
    input  wire  [2:0]              op,
    input  wire  [7:0]              write_index,
    input  wire  signed [31:0]      search_value,
    input  wire  signed [31:0]      new_value,
    output logic                    done,
    output logic                    found,
    output logic [7:0]              position,
    output logic [8:0]              tally,
    output logic signed [31:0]      nearest_value
);

    localparam int CW = $clog2(DEPTH + 1);

    logic [8:0]    active_count_reg;
    logic [CW-1:0] n_used;
    logic          cfg_write;
    ase_cmd_t      cmd;
    ase_status_t   status;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_count_reg <= '0;
        end
        else if (cfg_write && paddr[2] == ASE_IDX_ACTIVE_COUNT)
        begin
            active_count_reg <= pwdata[8:0];
        end
    end

    assign prdata = (paddr[2] == ASE_IDX_ACTIVE_COUNT) ? {23'd0, active_count_reg} : 32'd0;

    always_comb
    begin
        if (32'(active_count_reg) > 32'(DEPTH))
        begin
            n_used = CW'(DEPTH);
        end
        else
        begin
            n_used = CW'(active_count_reg);
        end
    end

    ase_controller u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .op     (op),
        .status (status),
        .cmd    (cmd),
        .busy   (busy),
        .done   (done)
    );

    ase_datapath #(
        .DEPTH (DEPTH)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .n_used        (n_used),
        .write_index   (write_index),
        .search_value  (search_value),
        .new_value     (new_value),
        .status        (status),
        .found         (found),
        .position      (position),
        .tally         (tally),
        .nearest_value (nearest_value)
    );

    // An accepted command always leaves idle.
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("accepted command did not raise busy");

    // The result beat returns the engine to idle.
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !busy)
        else $error("engine stayed busy after result beat");

    // Busy only drops right after a result beat.
    a_busy_fall: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> $past(done))
        else $error("busy dropped without a result beat");

    // A result beat only comes while a command is in flight.
    a_done_only_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> busy)
        else $error("result beat outside a command");

endmodule

`default_nettype wire

// ===== rtl/core/ase_datapath.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Array search engine datapath
// Element memory with a registered read port, the linear scan compare
// pipeline, the binary search window and the result registers.
// ----------------------------------------------------------------------------
module ase_datapath
    import ase_pkg::*;
#(
    parameter int DEPTH = ASE_DEPTH
) (
    input  wire                                clk,
    input  wire                                rst_n,
    input  ase_cmd_t                           cmd,
    input  wire  [$clog2(DEPTH+1)-1:0]         n_used,
    input  wire  [7:0]                         write_index,
    input  wire  signed [31:0]                 search_value,
    input  wire  signed [31:0]                 new_value,
    output ase_status_t                        status,
    output logic                               found,
    output logic [7:0]                         position,
    output logic [8:0]                         tally,
    output logic signed [31:0]                 nearest_value
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic [31:0]           mem_q [DEPTH];
    logic [31:0]           rd_data_reg;

    logic [7:0]            widx_reg;
    logic signed [31:0]    key_reg;
    logic signed [31:0]    newval_reg;

    logic [CW-1:0]         scan_idx_reg;
    logic                  pipe_valid_reg;
    logic [AW-1:0]         pipe_idx_reg;

    logic signed [CW:0]    lo_reg;
    logic signed [CW:0]    hi_reg;
    logic [AW-1:0]         mid_reg;

    logic                  found_reg;
    logic [AW-1:0]         pos_reg;
    logic [8:0]            tally_reg;
    logic signed [31:0]    nval_reg;
    logic                  have_reg;
    logic [32:0]           best_reg;

    logic                  widx_ok;
    logic                  mem_we;
    logic [AW-1:0]         mem_waddr;
    logic [31:0]           mem_wdata;
    logic [AW-1:0]         rd_addr;

    logic signed [31:0]    elem;
    logic                  cmp_eq;
    logic                  cmp_lt;
    logic signed [32:0]    d_pos;
    logic signed [32:0]    d_neg;
    logic [32:0]           abs_diff;
    logic                  closer;

    logic signed [CW+1:0]  mid_sum;
    logic [AW-1:0]         mid;
    logic signed [CW:0]    mid_ext;
    logic signed [CW:0]    one_ext;

    assign widx_ok   = 32'(widx_reg) < 32'(DEPTH);
    assign mem_we    = (cmd.wr_item && widx_ok) || (cmd.wr_repl && found_reg);
    assign mem_waddr = cmd.wr_repl ? pos_reg : AW'(widx_reg);
    assign mem_wdata = cmd.wr_repl ? newval_reg : key_reg;

    assign mid_sum = (CW+2)'(lo_reg) + (CW+2)'(hi_reg);
    assign mid     = mid_sum[AW:1];
    assign rd_addr = cmd.bs_issue ? mid : scan_idx_reg[AW-1:0];

    assign mid_ext = $signed({1'b0, CW'(mid_reg)});
    assign one_ext = $signed((CW+1)'(1));

    assign elem     = $signed(rd_data_reg);
    assign cmp_eq   = elem == key_reg;
    assign cmp_lt   = elem < key_reg;
    assign d_pos    = {elem[31], elem} - {key_reg[31], key_reg};
    assign d_neg    = {key_reg[31], key_reg} - {elem[31], elem};
    assign abs_diff = cmp_lt ? d_neg : d_pos;
    assign closer   = !have_reg || (abs_diff < best_reg);

    assign status.scan_more   = scan_idx_reg < n_used;
    assign status.range_empty = lo_reg > hi_reg;
    assign status.cmp_eq      = cmp_eq;

    // Element store: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem_q[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= mem_q[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            widx_reg   <= write_index;
            key_reg    <= search_value;
            newval_reg <= new_value;
        end
        if (cmd.scan_issue)
        begin
            pipe_idx_reg <= scan_idx_reg[AW-1:0];
        end
        if (cmd.bs_issue)
        begin
            mid_reg <= mid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_idx_reg   <= '0;
            pipe_valid_reg <= 1'b0;
            lo_reg         <= '0;
            hi_reg         <= '0;
            found_reg      <= 1'b0;
            pos_reg        <= '0;
            tally_reg      <= '0;
            nval_reg       <= '0;
            have_reg       <= 1'b0;
            best_reg       <= '0;
        end
        else if (cmd.load)
        begin
            scan_idx_reg   <= '0;
            pipe_valid_reg <= 1'b0;
            lo_reg         <= '0;
            hi_reg         <= $signed({1'b0, n_used}) - one_ext;
            found_reg      <= 1'b0;
            pos_reg        <= '0;
            tally_reg      <= '0;
            nval_reg       <= '0;
            have_reg       <= 1'b0;
            best_reg       <= '0;
        end
        else
        begin
            pipe_valid_reg <= cmd.scan_issue;
            if (cmd.scan_issue)
            begin
                scan_idx_reg <= scan_idx_reg + CW'(1);
            end

            // Linear scan: the beat read last cycle is compared now.
            if (pipe_valid_reg && cmp_eq)
            begin
                found_reg <= 1'b1;
                case (cmd.mode)
                    OP_FIRST:
                    begin
                        if (!found_reg)
                        begin
                            pos_reg <= pipe_idx_reg;
                        end
                    end
                    OP_COUNT:
                    begin
                        tally_reg <= tally_reg + 9'd1;
                    end
                    OP_LAST, OP_REPLACE:
                    begin
                        pos_reg <= pipe_idx_reg;
                    end
                    default:
                    begin
                    end
                endcase
            end

            if (cmd.bs_step)
            begin
                if (cmd.mode == OP_NEAREST && closer)
                begin
                    have_reg <= 1'b1;
                    best_reg <= abs_diff;
                    pos_reg  <= mid_reg;
                    nval_reg <= elem;
                end
                if (cmp_eq)
                begin
                    found_reg <= 1'b1;
                    if (cmd.mode == OP_BINARY)
                    begin
                        pos_reg <= mid_reg;
                    end
                end
                else
                begin
                    if (cmp_lt)
                    begin
                        lo_reg <= mid_ext + one_ext;
                    end
                    else
                    begin
                        hi_reg <= mid_ext - one_ext;
                    end
                    if (cmd.mode == OP_BINARY)
                    begin
                        tally_reg <= tally_reg + 9'd1;
                    end
                end
            end
        end
    end

    assign found         = found_reg;
    assign position      = 8'(pos_reg);
    assign tally         = tally_reg;
    assign nearest_value = nval_reg;

endmodule

`default_nettype wire

// ===== rtl/core/ase_controller.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Array search engine sequencer
// One-hot state machine that accepts a command, steps the datapath through
// the write, the scan or the binary search and raises the result strobe.
// ----------------------------------------------------------------------------
module ase_controller
    import ase_pkg::*;
(
    input  wire          clk,
    input  wire          rst_n,
    input  wire          start,
    input  wire  [2:0]   op,
    input  ase_status_t  status,
    output ase_cmd_t     cmd,
    output logic         busy,
    output logic         done
);

    typedef enum logic [6:0] {
        S_IDLE     = 7'b0000001,
        S_WRITE    = 7'b0000010,
        S_SCAN     = 7'b0000100,
        S_REPL     = 7'b0001000,
        S_BS_ISSUE = 7'b0010000,
        S_BS_CMP   = 7'b0100000,
        S_DONE     = 7'b1000000
    } ase_state_t;

    ase_state_t state_reg;
    ase_state_t state_next;
    ase_op_t    op_reg;
    ase_op_t    op_next;

    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        cmd            = '0;
        cmd.mode       = op_reg;
        done           = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load = 1'b1;
                    op_next  = ase_op_t'(op);
                    case (ase_op_t'(op))
                        OP_WRITE:                                  state_next = S_WRITE;
                        OP_FIRST, OP_COUNT, OP_LAST, OP_REPLACE:   state_next = S_SCAN;
                        OP_BINARY, OP_NEAREST:                     state_next = S_BS_ISSUE;
                        default:                                   state_next = S_DONE;
                    endcase
                end
            end
            S_WRITE:
            begin
                cmd.wr_item = 1'b1;
                state_next  = S_DONE;
            end
            S_SCAN:
            begin
                // The final compare lands on the same edge that leaves this state.
                if (status.scan_more)
                begin
                    cmd.scan_issue = 1'b1;
                end
                else if (op_reg == OP_REPLACE)
                begin
                    state_next = S_REPL;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_REPL:
            begin
                cmd.wr_repl = 1'b1;
                state_next  = S_DONE;
            end
            S_BS_ISSUE:
            begin
                if (status.range_empty)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    cmd.bs_issue = 1'b1;
                    state_next   = S_BS_CMP;
                end
            end
            S_BS_CMP:
            begin
                cmd.bs_step = 1'b1;
                state_next  = status.cmp_eq ? S_DONE : S_BS_ISSUE;
            end
            S_DONE:
            begin
                done       = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            op_reg    <= OP_WRITE;
        end
        else
        begin
            state_reg <= state_next;
            op_reg    <= op_next;
        end
    end

    assign busy = state_reg != S_IDLE;

endmodule

`default_nettype wire
